FILE: rtl/otsi_pkg.sv
// shared types and constants for the overtemp safety interlock
package otsi_pkg;

  localparam int unsigned TempW  = 16;
  localparam int unsigned RiseW  = 15;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned FaultW = 2;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;

  // fault codes
  localparam logic [FaultW-1:0] FAULT_NONE     = 2'd0;
  localparam logic [FaultW-1:0] FAULT_SENSOR   = 2'd1;
  localparam logic [FaultW-1:0] FAULT_STUCK    = 2'd2;
  localparam logic [FaultW-1:0] FAULT_OVERTEMP = 2'd3;

  // item function codes
  localparam logic FUNC_CHECK = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  // register index (word address)
  localparam logic [2:0] REG_CUTOFF    = 3'd0;
  localparam logic [2:0] REG_RECOVERY  = 3'd1;
  localparam logic [2:0] REG_STUCK_RISE = 3'd2;
  localparam logic [2:0] REG_STUCK_DLY = 3'd3;
  localparam logic [2:0] REG_OVER_DLY  = 3'd4;

  typedef struct packed {
    logic [TempW-1:0] cutoff_temperature;
    logic [TempW-1:0] recovery_temperature;
    logic [RiseW-1:0] stuck_rise_threshold;
    logic [TimeW-1:0] stuck_check_delay_ms;
    logic [TimeW-1:0] overtemp_wait_ms;
  } cfg_t;

  typedef struct packed {
    logic             func;
    logic [TempW-1:0] temperature;
    logic             sensor_failed;
    logic             reading_valid;
    logic [TimeW-1:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [FaultW-1:0] latched_fault;
    logic [TempW-1:0]  fault_temperature;
    logic              in_cutoff;
    logic [TempW-1:0]  cutoff_start_temperature;
    logic [TimeW-1:0]  cutoff_start_ms;
    logic              stuck_check_done;
  } state_t;

  typedef struct packed {
    logic [FaultW-1:0] fault_code;
    logic [TempW-1:0]  trigger_temperature;
    logic              relay_force_off;
    logic              fault_event;
    logic              cutoff_active;
    logic              stuck_checked;
    logic [TimeW-1:0]  cutoff_elapsed_ms;
    logic              click_clear_allowed;
  } result_t;

endpackage

FILE: rtl/otsi_regs.sv
// configuration registers with apb-style access
module otsi_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [otsi_pkg::AddrW-1:0] paddr,
  input  logic [otsi_pkg::DataW-1:0] pwdata,
  output logic [otsi_pkg::DataW-1:0] prdata,
  output otsi_pkg::cfg_t             cfg_o
);

  otsi_pkg::cfg_t cfg_q;
  logic           wr_en;
  logic [2:0]     reg_idx;

  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[otsi_pkg::AddrW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cutoff_temperature   <= 16'sd1920;
      cfg_q.recovery_temperature <= 16'sd1600;
      cfg_q.stuck_rise_threshold <= 15'd80;
      cfg_q.stuck_check_delay_ms <= 32'd30000;
      cfg_q.overtemp_wait_ms     <= 32'd60000;
    end else if (wr_en) begin
      unique case (reg_idx)
        otsi_pkg::REG_CUTOFF:     cfg_q.cutoff_temperature   <= pwdata[15:0];
        otsi_pkg::REG_RECOVERY:   cfg_q.recovery_temperature <= pwdata[15:0];
        otsi_pkg::REG_STUCK_RISE: cfg_q.stuck_rise_threshold <= pwdata[14:0];
        otsi_pkg::REG_STUCK_DLY:  cfg_q.stuck_check_delay_ms <= pwdata;
        otsi_pkg::REG_OVER_DLY:   cfg_q.overtemp_wait_ms     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      otsi_pkg::REG_CUTOFF:     prdata = {16'd0, cfg_q.cutoff_temperature};
      otsi_pkg::REG_RECOVERY:   prdata = {16'd0, cfg_q.recovery_temperature};
      otsi_pkg::REG_STUCK_RISE: prdata = {17'd0, cfg_q.stuck_rise_threshold};
      otsi_pkg::REG_STUCK_DLY:  prdata = cfg_q.stuck_check_delay_ms;
      otsi_pkg::REG_OVER_DLY:   prdata = cfg_q.overtemp_wait_ms;
      default:                  prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/otsi_check.sv
// next-state and result logic for one check or clear word
module otsi_check (
  input  otsi_pkg::cfg_t    cfg_i,
  input  otsi_pkg::state_t  state_i,
  input  otsi_pkg::item_t   item_i,
  output otsi_pkg::state_t  state_o,
  output otsi_pkg::result_t result_o
);

  otsi_pkg::state_t           nxt;
  logic                       ev;
  logic                       force_off;
  logic                       stuck_hit;
  logic [otsi_pkg::TimeW-1:0] elapsed;
  logic [17:0]                temp_ext;
  logic [17:0]                limit_ext;

  always_comb begin
    nxt       = state_i;
    ev        = 1'b0;
    force_off = 1'b0;
    stuck_hit = 1'b0;
    elapsed   = '0;
    temp_ext  = {{2{item_i.temperature[15]}}, item_i.temperature};
    limit_ext = '0;
    if (item_i.func == otsi_pkg::FUNC_CLEAR) begin
      nxt = '0;
    end else if (state_i.latched_fault == otsi_pkg::FAULT_NONE && item_i.reading_valid) begin
      if (item_i.sensor_failed) begin
        nxt.latched_fault     = otsi_pkg::FAULT_SENSOR;
        nxt.fault_temperature = item_i.temperature;
        ev                    = 1'b1;
        force_off             = 1'b1;
      end else if ($signed(item_i.temperature) >= $signed(cfg_i.cutoff_temperature)) begin
        if (!state_i.in_cutoff) begin
          nxt.in_cutoff                = 1'b1;
          nxt.cutoff_start_temperature = item_i.temperature;
          nxt.cutoff_start_ms          = item_i.now_ms;
          nxt.stuck_check_done         = 1'b0;
          force_off                    = 1'b1;
        end
        elapsed   = item_i.now_ms - nxt.cutoff_start_ms;
        limit_ext = {{2{nxt.cutoff_start_temperature[15]}}, nxt.cutoff_start_temperature}
                    + {3'd0, cfg_i.stuck_rise_threshold};
        if (!nxt.stuck_check_done && elapsed >= cfg_i.stuck_check_delay_ms) begin
          nxt.stuck_check_done = 1'b1;
          if ($signed(temp_ext) > $signed(limit_ext)) begin
            nxt.latched_fault     = otsi_pkg::FAULT_STUCK;
            nxt.fault_temperature = nxt.cutoff_start_temperature;
            ev                    = 1'b1;
            force_off             = 1'b1;
            stuck_hit             = 1'b1;
          end
        end
        if (!stuck_hit && elapsed >= cfg_i.overtemp_wait_ms) begin
          nxt.latched_fault     = otsi_pkg::FAULT_OVERTEMP;
          nxt.fault_temperature = nxt.cutoff_start_temperature;
          ev                    = 1'b1;
          force_off             = 1'b1;
        end
      end else if (state_i.in_cutoff &&
                   $signed(item_i.temperature) < $signed(cfg_i.recovery_temperature)) begin
        nxt.in_cutoff                = 1'b0;
        nxt.cutoff_start_temperature = '0;
        nxt.cutoff_start_ms          = '0;
        nxt.stuck_check_done         = 1'b0;
      end
    end
  end

  assign state_o                      = nxt;
  assign result_o.fault_code          = nxt.latched_fault;
  assign result_o.trigger_temperature = nxt.fault_temperature;
  assign result_o.relay_force_off     = force_off;
  assign result_o.fault_event         = ev;
  assign result_o.cutoff_active       = nxt.in_cutoff;
  assign result_o.stuck_checked       = nxt.stuck_check_done;
  assign result_o.cutoff_elapsed_ms   = nxt.in_cutoff ? (item_i.now_ms - nxt.cutoff_start_ms)
                                                      : '0;
  assign result_o.click_clear_allowed = (nxt.latched_fault != otsi_pkg::FAULT_STUCK);

endmodule

FILE: rtl/overtemp_safety_interlock_core.sv
// top level of the heater overtemp safety interlock
//
// usage
//   input channel: in_valid_i with one word of func, temperature, sensor flags and
//   now_ms; a word is taken when in_valid_i is high and in_stall_o is low
//   output channel: out_valid_o with one result word per input word; the word is
//   taken when out_valid_o is high and out_stall_i is low
//   registers are written through the apb-style port while no word is in flight
//   path: the word is held in the input register, then its result in the result
//   register; the check itself is combinational, with compares, one add and two
//   subtracts
//   throughput: one word per cycle while the receiver does not stall; interlock state
//   updates as the word moves from the input register into the result register
//   stall: when the receiver stalls, the result register holds, the input register
//   fills and then in_stall_o rises; no word is lost or repeated
//   reset: all interlock state clears (no fault, no cutoff), registers return to
//   their default thresholds and delays, both pipeline stages empty
module overtemp_safety_interlock_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [otsi_pkg::AddrW-1:0]  paddr,
  input  logic [otsi_pkg::DataW-1:0]  pwdata,
  output logic [otsi_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        func_i,
  input  logic signed [15:0]          temperature_i,
  input  logic                        sensor_failed_i,
  input  logic                        reading_valid_i,
  input  logic [31:0]                 now_ms_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  fault_code_o,
  output logic signed [15:0]          trigger_temperature_o,
  output logic                        relay_force_off_o,
  output logic                        fault_event_o,
  output logic                        cutoff_active_o,
  output logic                        stuck_checked_o,
  output logic [31:0]                 cutoff_elapsed_ms_o,
  output logic                        click_clear_allowed_o
);

  otsi_pkg::cfg_t    cfg;
  otsi_pkg::item_t   item_q;
  otsi_pkg::state_t  state_q;
  otsi_pkg::state_t  state_d;
  otsi_pkg::result_t res_d;
  otsi_pkg::result_t res_q;
  logic              item_vld_q;
  logic              out_vld_q;
  logic              out_adv;
  logic              item_move;
  logic              in_take;

  assign pready = 1'b1;

  otsi_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  otsi_check u_check (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  assign out_adv   = !out_vld_q || !out_stall_i;
  assign item_move = item_vld_q && out_adv;
  assign in_stall_o = item_vld_q && !out_adv;
  assign in_take   = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      state_q    <= '0;
    end else begin
      if (in_take) begin
        item_vld_q <= 1'b1;
      end else if (item_move) begin
        item_vld_q <= 1'b0;
      end
      if (out_adv) begin
        out_vld_q <= item_vld_q;
      end
      if (item_move) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.func          <= func_i;
      item_q.temperature   <= temperature_i;
      item_q.sensor_failed <= sensor_failed_i;
      item_q.reading_valid <= reading_valid_i;
      item_q.now_ms        <= now_ms_i;
    end
    if (item_move) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o           = out_vld_q;
  assign fault_code_o          = res_q.fault_code;
  assign trigger_temperature_o = res_q.trigger_temperature;
  assign relay_force_off_o     = res_q.relay_force_off;
  assign fault_event_o         = res_q.fault_event;
  assign cutoff_active_o       = res_q.cutoff_active;
  assign stuck_checked_o       = res_q.stuck_checked;
  assign cutoff_elapsed_ms_o   = res_q.cutoff_elapsed_ms;
  assign click_clear_allowed_o = res_q.click_clear_allowed;

  a_event_forces_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.fault_event |-> res_q.relay_force_off &&
      res_q.fault_code != otsi_pkg::FAULT_NONE)
    else $error("fault word without relay force off or fault code");

  a_fault_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.latched_fault != otsi_pkg::FAULT_NONE &&
      !(item_move && item_q.func == otsi_pkg::FUNC_CLEAR)
    |=> state_q.latched_fault == $past(state_q.latched_fault))
    else $error("latched fault changed without a clear word");

  a_elapsed_only_in_cutoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !res_q.cutoff_active |-> res_q.cutoff_elapsed_ms == '0 &&
      !res_q.stuck_checked)
    else $error("cutoff timing shown outside cutoff");

  a_stall_holds_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> item_vld_q && $stable(state_q))
    else $error("interlock state moved while stalled");

endmodule
